// File: rtl/ctrp_pkg.sv
// Package for the constant turn rate position predictor.
// Holds widths, stage map, fixed-point constants, the CORDIC arctangent table
// and the sideband record. No dependencies.
`timescale 1ns / 1ps

package ctrp_pkg;

    // field widths
    localparam int T_W    = 20;
    localparam int V_W    = 24;
    localparam int W_W    = 24;
    localparam int Q_W    = 16;
    localparam int P_W    = 40;
    localparam int THR_W  = 23;
    localparam int MODE_W = 2;

    // internal widths
    localparam int ANG_W  = 34;   // CORDIC x, y, z in Q.30
    localparam int TH_W   = 38;   // magnitude of the unreduced angle
    localparam int R_W    = 34;   // rotation matrix entries, Q.28
    localparam int DIV_W  = 24;   // divisor |turn_rate|
    localparam int SH_W   = 5;    // CORDIC shift amount
    localparam int D_W    = 41;   // body-frame offsets
    localparam int PP_W   = 54;   // rotation partial products
    localparam int TERM_W = 48;   // rotated terms
    localparam int O_W    = 49;   // rotated offsets
    localparam int PRD_W  = 57;   // v * (1 - cos) and v * sin

    // pipeline depth per section
    localparam int CORDIC_STEPS = 20;
    localparam int MOD_STEPS    = 5;
    localparam int DIV_BITS     = 40;

    // stage map
    localparam int ST_MOD0  = 1;
    localparam int ST_FOLD  = ST_MOD0 + MOD_STEPS;
    localparam int ST_CORD0 = ST_FOLD + 1;
    localparam int ST_MUL   = ST_CORD0 + CORDIC_STEPS;
    localparam int ST_ABS   = ST_MUL + 1;
    localparam int ST_DIV0  = ST_ABS + 1;
    localparam int ST_DQ    = ST_DIV0 + DIV_BITS;
    localparam int ST_R1    = ST_DQ + 1;
    localparam int ST_R2    = ST_R1 + 1;
    localparam int ST_R3    = ST_R2 + 1;
    localparam int ST_FIN   = ST_R3 + 1;
    localparam int N_STAGES = ST_FIN + 1;

    // frame modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VEH  = 2'd2;

    // fixed-point constants
    localparam logic [THR_W-1:0]         THR_RESET  = 23'd105;
    localparam logic [TH_W-1:0]          TWO_PI_MAG = 38'd6746518852;
    localparam logic signed [TH_W:0]     TWO_PI_S   = 39'sd6746518852;
    localparam logic signed [TH_W:0]     PI_S       = 39'sd3373259426;
    localparam logic signed [TH_W:0]     HALF_PI_S  = 39'sd1686629713;
    localparam logic signed [ANG_W-1:0]  GAIN_Q30   = 34'sd652032874;
    localparam logic signed [ANG_W:0]    ONE_Q30    = 35'sd1073741824;
    localparam logic signed [R_W-1:0]    ONE_Q28    = 34'sd268435456;
    localparam logic signed [P_W+9:0]    POS_MAX    = 50'sd549755813887;
    localparam logic signed [P_W+9:0]    POS_MIN    = -50'sd549755813888;

    // state carried beside the arithmetic
    typedef struct packed {
        logic                     straight;
        logic                     th_neg;
        logic                     flip;
        logic                     w_neg;
        logic                     negx;
        logic                     negy;
        logic signed [22:0]       dys;
        logic signed [V_W-1:0]    v;
        logic [DIV_W-1:0]         w_mag;
        logic [MODE_W-1:0]        mode;
        logic signed [R_W-1:0]    r00;
        logic signed [R_W-1:0]    r01;
        logic signed [R_W-1:0]    r10;
        logic signed [R_W-1:0]    r11;
        logic signed [P_W-1:0]    pos_x;
        logic signed [P_W-1:0]    pos_y;
    } side_t;

    // atan(2^-i) in Q.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048576;
            11:      a = 34'sd524288;
            12:      a = 34'sd262144;
            13:      a = 34'sd131072;
            14:      a = 34'sd65536;
            15:      a = 34'sd32768;
            16:      a = 34'sd16384;
            17:      a = 34'sd8192;
            18:      a = 34'sd4096;
            19:      a = 34'sd2048;
            20:      a = 34'sd1024;
            21:      a = 34'sd512;
            22:      a = 34'sd256;
            23:      a = 34'sd128;
            24:      a = 34'sd64;
            25:      a = 34'sd32;
            26:      a = 34'sd16;
            27:      a = 34'sd8;
            28:      a = 34'sd4;
            29:      a = 34'sd2;
            30:      a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    // multiple of 2*pi taken off by reduction cell j (largest first)
    function automatic logic [TH_W-1:0] mod_step(input int unsigned j);
        return TWO_PI_MAG << (MOD_STEPS - 1 - j);
    endfunction

endpackage

// File: rtl/ctrp_mod_cell.sv
// One angle reduction cell: conditionally takes a fixed multiple of 2*pi off.
// Depends on ctrp_pkg.
`timescale 1ns / 1ps

module ctrp_mod_cell (
    input  logic                      clk,
    input  logic                      en,
    input  logic [ctrp_pkg::TH_W-1:0] step_val,
    input  logic [ctrp_pkg::TH_W-1:0] mag_in,
    output logic [ctrp_pkg::TH_W-1:0] mag_out
);
    import ctrp_pkg::*;

    logic [TH_W-1:0] mag_reg;
    logic [TH_W-1:0] mag_next;

    // compare and subtract
    always_comb
    begin
        mag_next = (mag_in >= step_val) ? (mag_in - step_val) : mag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag_out = mag_reg;

endmodule

// File: rtl/ctrp_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its own register.
// Depends on ctrp_pkg.
`timescale 1ns / 1ps

module ctrp_cordic_cell (
    input  logic                              clk,
    input  logic                              en,
    input  logic [ctrp_pkg::SH_W-1:0]         shift,
    input  logic signed [ctrp_pkg::ANG_W-1:0] atan_val,
    input  logic signed [ctrp_pkg::ANG_W-1:0] x_in,
    input  logic signed [ctrp_pkg::ANG_W-1:0] y_in,
    input  logic signed [ctrp_pkg::ANG_W-1:0] z_in,
    output logic signed [ctrp_pkg::ANG_W-1:0] x_out,
    output logic signed [ctrp_pkg::ANG_W-1:0] y_out,
    output logic signed [ctrp_pkg::ANG_W-1:0] z_out
);
    import ctrp_pkg::*;

    logic signed [ANG_W-1:0] x_reg, y_reg, z_reg;
    logic signed [ANG_W-1:0] x_next, y_next, z_next;
    logic signed [ANG_W-1:0] tx, ty;

    // rotate toward z = 0
    always_comb
    begin
        tx = x_in >>> shift;
        ty = y_in >>> shift;
        if (!z_in[ANG_W-1])
        begin
            x_next = x_in - ty;
            y_next = y_in + tx;
            z_next = z_in - atan_val;
        end
        else
        begin
            x_next = x_in + ty;
            y_next = y_in - tx;
            z_next = z_in + atan_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: rtl/ctrp_div_cell.sv
// One restoring division cell: produces one quotient bit, MSB first.
// Depends on ctrp_pkg.
`timescale 1ns / 1ps

module ctrp_div_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ctrp_pkg::DIV_W-1:0]    divisor,
    input  logic [ctrp_pkg::DIV_W-1:0]    rem_in,
    input  logic [ctrp_pkg::DIV_BITS-1:0] work_in,
    output logic [ctrp_pkg::DIV_W-1:0]    rem_out,
    output logic [ctrp_pkg::DIV_BITS-1:0] work_out
);
    import ctrp_pkg::*;

    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_BITS-1:0] work_reg, work_next;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                ge;

    // shift in next dividend bit, trial subtract
    always_comb
    begin
        trial     = {rem_in, work_in[DIV_BITS-1]};
        ge        = (trial >= {1'b0, divisor});
        diff      = trial - {1'b0, divisor};
        rem_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        work_next = {work_in[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign rem_out  = rem_reg;
    assign work_out = work_reg;

endmodule

// File: rtl/constant_turn_rate_position_predict_unit.sv
// Constant turn rate position predictor: top level pipeline and output stage.
// Depends on ctrp_pkg, ctrp_mod_cell, ctrp_cordic_cell, ctrp_div_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one request: horizon, speed,
//   yaw rate, quaternion, position and frame mode. Output channel
//   (out_valid / out_stall) returns est_x / est_y, saturated Q30.10.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes the small
//   yaw-rate threshold; cfg_ready is always high. Write it only when idle.
// Throughput: one request per cycle while in_stall is low; the pipeline is a
//   row of cells (5 angle reduction, CORDIC_STEPS rotation, 40 divider cells
//   per lane) that all advance together.
// Order: stage 0 register, reduction, fold, CORDIC, multiply, abs, divider,
//   offsets, rotation, frame select, position sum, then the output register.
// Reset: rst_n clears all valid bits and loads the threshold with 105.
// Receiver stall: the output register holds; one more result lands in a
//   skid register, then in_stall rises and the whole pipeline freezes
//   until the output is taken.
`timescale 1ns / 1ps

module constant_turn_rate_position_predict_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctrp_pkg::THR_W-1:0]          cfg_data,
    // request
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ctrp_pkg::T_W-1:0]            horizon_time,
    input  logic signed [ctrp_pkg::V_W-1:0]     speed,
    input  logic signed [ctrp_pkg::W_W-1:0]     turn_rate,
    input  logic signed [ctrp_pkg::Q_W-1:0]     quat_w,
    input  logic signed [ctrp_pkg::Q_W-1:0]     quat_x,
    input  logic signed [ctrp_pkg::Q_W-1:0]     quat_y,
    input  logic signed [ctrp_pkg::Q_W-1:0]     quat_z,
    input  logic signed [ctrp_pkg::P_W-1:0]     pos_x,
    input  logic signed [ctrp_pkg::P_W-1:0]     pos_y,
    input  logic [ctrp_pkg::MODE_W-1:0]         frame_mode,
    // result
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ctrp_pkg::P_W-1:0]     est_x,
    output logic signed [ctrp_pkg::P_W-1:0]     est_y
);
    import ctrp_pkg::*;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic [THR_W-1:0]    thr_reg;
    logic [N_STAGES-1:0] vld_reg;
    logic                skid_valid_reg;
    logic                out_valid_reg;
    logic                en;
    logic                take;

    side_t side_reg [N_STAGES];

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign take      = en && vld_reg[N_STAGES-1];

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // valid bits travel with the cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N_STAGES-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 0: products of inputs, straight-line test, rotation matrix
    // ------------------------------------------------------------------
    logic signed [44:0]     wt, vt;
    logic signed [44:0]     th_full;
    logic signed [44:0]     th_abs;
    logic signed [W_W:0]    w_ext, w_abs;
    logic [DIV_W-1:0]       w_mag;
    logic signed [31:0]     qxx, qyy, qzz, qxy, qwz;
    logic signed [R_W-1:0]  qxx34, qyy34, qzz34, qxy34, qwz34;
    side_t                  side0;
    logic [TH_W-1:0]        th_reg;

    always_comb
    begin
        wt      = turn_rate * $signed({1'b0, horizon_time});
        vt      = speed * $signed({1'b0, horizon_time});
        th_full = wt >>> 6;
        th_abs  = th_full[44] ? -th_full : th_full;
        w_ext   = (W_W+1)'(turn_rate);
        w_abs   = w_ext[W_W] ? -w_ext : w_ext;
        w_mag   = w_abs[DIV_W-1:0];

        qxx   = quat_x * quat_x;
        qyy   = quat_y * quat_y;
        qzz   = quat_z * quat_z;
        qxy   = quat_x * quat_y;
        qwz   = quat_w * quat_z;
        qxx34 = R_W'(qxx);
        qyy34 = R_W'(qyy);
        qzz34 = R_W'(qzz);
        qxy34 = R_W'(qxy);
        qwz34 = R_W'(qwz);

        side0          = '0;
        side0.straight = (turn_rate == '0) || (w_mag < {1'b0, thr_reg});
        side0.th_neg   = th_full[44];
        side0.w_neg    = turn_rate[W_W-1];
        side0.dys      = vt[44:22];
        side0.v        = speed;
        side0.w_mag    = w_mag;
        side0.mode     = frame_mode;
        side0.r00      = ONE_Q28 - ((qyy34 + qzz34) <<< 1);
        side0.r01      = (qxy34 - qwz34) <<< 1;
        side0.r10      = (qxy34 + qwz34) <<< 1;
        side0.r11      = ONE_Q28 - ((qxx34 + qzz34) <<< 1);
        side0.pos_x    = pos_x;
        side0.pos_y    = pos_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            th_reg      <= th_abs[TH_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // angle reduction cells: |theta| mod 2*pi
    // ------------------------------------------------------------------
    logic [TH_W-1:0] mod_out [MOD_STEPS];

    for (genvar gm = 0; gm < MOD_STEPS; gm++)
    begin : g_mod
        ctrp_mod_cell u_mod (
            .clk      (clk),
            .en       (en),
            .step_val (mod_step(gm)),
            .mag_in   ((gm == 0) ? th_reg : mod_out[(gm == 0) ? 0 : gm-1]),
            .mag_out  (mod_out[gm])
        );
    end

    // ------------------------------------------------------------------
    // fold into [-pi/2, pi/2]
    // ------------------------------------------------------------------
    logic signed [TH_W:0]     r0, r1, rz;
    logic                     fold_flip;
    logic signed [ANG_W-1:0]  fold_z_reg;

    always_comb
    begin
        r0 = side_reg[ST_FOLD-1].th_neg ? -$signed({1'b0, mod_out[MOD_STEPS-1]})
                                        : $signed({1'b0, mod_out[MOD_STEPS-1]});
        if (r0 > PI_S)
        begin
            r1 = r0 - TWO_PI_S;
        end
        else if (r0 <= -PI_S)
        begin
            r1 = r0 + TWO_PI_S;
        end
        else
        begin
            r1 = r0;
        end
        fold_flip = 1'b0;
        rz        = r1;
        if (r1 > HALF_PI_S)
        begin
            rz        = PI_S - r1;
            fold_flip = 1'b1;
        end
        else if (r1 < -HALF_PI_S)
        begin
            rz        = -PI_S - r1;
            fold_flip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_z_reg <= rz[ANG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC cells
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] cx [CORDIC_STEPS];
    logic signed [ANG_W-1:0] cy [CORDIC_STEPS];
    logic signed [ANG_W-1:0] cz [CORDIC_STEPS];

    for (genvar gc = 0; gc < CORDIC_STEPS; gc++)
    begin : g_cordic
        localparam int PREV = (gc == 0) ? 0 : gc - 1;
        ctrp_cordic_cell u_cell (
            .clk      (clk),
            .en       (en),
            .shift    (SH_W'(gc)),
            .atan_val (atan_q30(gc)),
            .x_in     ((gc == 0) ? GAIN_Q30 : cx[PREV]),
            .y_in     ((gc == 0) ? '0 : cy[PREV]),
            .z_in     ((gc == 0) ? fold_z_reg : cz[PREV]),
            .x_out    (cx[gc]),
            .y_out    (cy[gc]),
            .z_out    (cz[gc])
        );
    end

    // ------------------------------------------------------------------
    // numerators: v*(1 - cos) and v*sin
    // ------------------------------------------------------------------
    logic signed [ANG_W:0]   cos35, ncos35;
    logic signed [32:0]      ncos33, sin33;
    logic signed [PRD_W-1:0] mul_x_reg, mul_y_reg;

    always_comb
    begin
        cos35  = side_reg[ST_MUL-1].flip ? -(ANG_W+1)'(cx[CORDIC_STEPS-1])
                                         : (ANG_W+1)'(cx[CORDIC_STEPS-1]);
        ncos35 = ONE_Q30 - cos35;
        ncos33 = ncos35[32:0];
        sin33  = cy[CORDIC_STEPS-1][32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_x_reg <= side_reg[ST_MUL-1].v * ncos33;
            mul_y_reg <= side_reg[ST_MUL-1].v * sin33;
        end
    end

    // ------------------------------------------------------------------
    // magnitudes and quotient signs; /2^16 folded into the dividend
    // ------------------------------------------------------------------
    logic signed [PRD_W-1:0] mag_x, mag_y;
    logic [DIV_BITS-1:0]     abs_x_reg, abs_y_reg;
    logic                    abs_negx, abs_negy;

    always_comb
    begin
        mag_x    = mul_x_reg[PRD_W-1] ? -mul_x_reg : mul_x_reg;
        mag_y    = mul_y_reg[PRD_W-1] ? -mul_y_reg : mul_y_reg;
        abs_negx = mul_x_reg[PRD_W-1] ^ side_reg[ST_ABS-1].w_neg;
        abs_negy = mul_y_reg[PRD_W-1] ^ side_reg[ST_ABS-1].w_neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_x_reg <= mag_x[DIV_BITS+15:16];
            abs_y_reg <= mag_y[DIV_BITS+15:16];
        end
    end

    // ------------------------------------------------------------------
    // divider cells, one lane per axis
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]    rx [DIV_BITS];
    logic [DIV_W-1:0]    ry [DIV_BITS];
    logic [DIV_BITS-1:0] qx [DIV_BITS];
    logic [DIV_BITS-1:0] qy [DIV_BITS];

    for (genvar gd = 0; gd < DIV_BITS; gd++)
    begin : g_div
        localparam int PREV = (gd == 0) ? 0 : gd - 1;
        ctrp_div_cell u_divx (
            .clk      (clk),
            .en       (en),
            .divisor  (side_reg[ST_DIV0+gd-1].w_mag),
            .rem_in   ((gd == 0) ? '0 : rx[PREV]),
            .work_in  ((gd == 0) ? abs_x_reg : qx[PREV]),
            .rem_out  (rx[gd]),
            .work_out (qx[gd])
        );
        ctrp_div_cell u_divy (
            .clk      (clk),
            .en       (en),
            .divisor  (side_reg[ST_DIV0+gd-1].w_mag),
            .rem_in   ((gd == 0) ? '0 : ry[PREV]),
            .work_in  ((gd == 0) ? abs_y_reg : qy[PREV]),
            .rem_out  (ry[gd]),
            .work_out (qy[gd])
        );
    end

    // ------------------------------------------------------------------
    // body-frame offsets
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] qx41, qy41, sx, sy;
    logic signed [D_W-1:0] dx_reg, dy_reg;

    always_comb
    begin
        qx41 = $signed({1'b0, qx[DIV_BITS-1]});
        qy41 = $signed({1'b0, qy[DIV_BITS-1]});
        sx   = side_reg[ST_DQ-1].negx ? -qx41 : qx41;
        sy   = side_reg[ST_DQ-1].negy ? -qy41 : qy41;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_reg[ST_DQ-1].straight)
            begin
                dx_reg <= '0;
                dy_reg <= D_W'(side_reg[ST_DQ-1].dys);
            end
            else
            begin
                dx_reg <= -sx;
                dy_reg <= sy;
            end
        end
    end

    // ------------------------------------------------------------------
    // rotation: split products (high and low halves of |d|)
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] pd  [4];
    logic signed [R_W-1:0] pr  [4];
    logic signed [D_W-1:0] pd_abs [4];
    logic signed [R_W:0]   pr_abs [4];
    logic [PP_W-1:0]       ph_reg [4];
    logic [PP_W-1:0]       pl_reg [4];
    logic [3:0]            pneg_reg;
    logic [PP_W:0]         plo    [4];
    logic [TERM_W-2:0]     pmag   [4];
    logic signed [TERM_W-1:0] term_reg [4];

    always_comb
    begin
        pd[0] = dx_reg;
        pd[1] = dy_reg;
        pd[2] = dx_reg;
        pd[3] = dy_reg;
        pr[0] = side_reg[ST_R1-1].r00;
        pr[1] = side_reg[ST_R1-1].r01;
        pr[2] = side_reg[ST_R1-1].r10;
        pr[3] = side_reg[ST_R1-1].r11;
        for (int k = 0; k < 4; k++)
        begin
            pd_abs[k] = pd[k][D_W-1] ? -pd[k] : pd[k];
            pr_abs[k] = pr[k][R_W-1] ? -(R_W+1)'(pr[k]) : (R_W+1)'(pr[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ph_reg[k]   <= pd_abs[k][39:20] * pr_abs[k][R_W-1:0];
                pl_reg[k]   <= pd_abs[k][19:0] * pr_abs[k][R_W-1:0];
                pneg_reg[k] <= pd[k][D_W-1] ^ pr[k][R_W-1];
            end
        end
    end

    // recombine and truncate toward zero after the Q.28 shift
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            plo[k]  = {(PP_W-27)'(0), ph_reg[k][7:0], 20'd0} + {1'b0, pl_reg[k]};
            pmag[k] = (TERM_W-1)'(ph_reg[k][PP_W-1:8]) + (TERM_W-1)'(plo[k][PP_W:28]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                term_reg[k] <= pneg_reg[k] ? -$signed({1'b0, pmag[k]})
                                           : $signed({1'b0, pmag[k]});
            end
        end
    end

    // ------------------------------------------------------------------
    // frame selection; offsets are delayed to line up with the terms
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] dx_d1_reg, dy_d1_reg, dx_d2_reg, dy_d2_reg;
    logic signed [O_W-1:0] ox_reg, oy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_d1_reg <= dx_reg;
            dy_d1_reg <= dy_reg;
            dx_d2_reg <= dx_d1_reg;
            dy_d2_reg <= dy_d1_reg;
            case (side_reg[ST_R3-1].mode)
                MODE_QUAT:
                begin
                    ox_reg <= O_W'(term_reg[0]) + O_W'(term_reg[1]);
                    oy_reg <= O_W'(term_reg[2]) + O_W'(term_reg[3]);
                end
                MODE_VEH:
                begin
                    ox_reg <= O_W'(dy_d2_reg);
                    oy_reg <= -O_W'(dx_d2_reg);
                end
                default:
                begin
                    ox_reg <= O_W'(dx_d2_reg);
                    oy_reg <= O_W'(dy_d2_reg);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // add to position and saturate
    // ------------------------------------------------------------------
    logic signed [P_W+9:0] sum_x, sum_y;
    logic signed [P_W-1:0] fin_x_reg, fin_y_reg;

    always_comb
    begin
        sum_x = (P_W+10)'(side_reg[ST_FIN-1].pos_x) + (P_W+10)'(ox_reg);
        sum_y = (P_W+10)'(side_reg[ST_FIN-1].pos_y) + (P_W+10)'(oy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_x_reg <= (sum_x > POS_MAX) ? POS_MAX[P_W-1:0] :
                         (sum_x < POS_MIN) ? POS_MIN[P_W-1:0] : sum_x[P_W-1:0];
            fin_y_reg <= (sum_y > POS_MAX) ? POS_MAX[P_W-1:0] :
                         (sum_y < POS_MIN) ? POS_MIN[P_W-1:0] : sum_y[P_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sideband chain; fold and abs stages add their flags
    // ------------------------------------------------------------------
    function automatic side_t set_flip(input side_t s, input logic f);
        side_t r;
        r      = s;
        r.flip = f;
        return r;
    endfunction

    function automatic side_t set_negs(input side_t s, input logic nx, input logic ny);
        side_t r;
        r      = s;
        r.negx = nx;
        r.negy = ny;
        return r;
    endfunction

    for (genvar gs = 1; gs < N_STAGES; gs++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (gs == ST_FOLD)
                begin
                    side_reg[gs] <= set_flip(side_reg[gs-1], fold_flip);
                end
                else if (gs == ST_ABS)
                begin
                    side_reg[gs] <= set_negs(side_reg[gs-1], abs_negx, abs_negy);
                end
                else
                begin
                    side_reg[gs] <= side_reg[gs-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output register and skid register
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_x_reg <= skid_x_reg;
                out_y_reg <= skid_y_reg;
            end
            else if (take)
            begin
                out_x_reg <= fin_x_reg;
                out_y_reg <= fin_y_reg;
            end
        end
        else if (take)
        begin
            skid_x_reg <= fin_x_reg;
            skid_y_reg <= fin_y_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign est_x     = out_x_reg;
    assign est_y     = out_y_reg;

endmodule

// File: rtl/ctrp_checker.sv
// Port-level checks for the position predictor, bound to the top level.
// Depends on ctrp_pkg.
`timescale 1ns / 1ps

module ctrp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic signed [ctrp_pkg::P_W-1:0] est_x,
    input logic signed [ctrp_pkg::P_W-1:0] est_y
);
    import ctrp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(est_x) && $stable(est_y))
        else $error("stalled result changed");

    // input is only held off while a result waits
    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending result");

    // input back-pressure starts only after the receiver stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("in_stall rose without output stall");

    // a taken result frees the skid register
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !in_stall)
        else $error("in_stall held after result taken");

endmodule

bind constant_turn_rate_position_predict_unit ctrp_checker u_ctrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .est_x     (est_x),
    .est_y     (est_y)
);
